// ----- sv/rlerac_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlerac_pkg
// Shared widths, limits and types of the run-length coder with checksum.
// ----------------------------------------------------------------------------
package rlerac_pkg;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned CKSUM_W = 32;
  localparam int unsigned LEN_W   = 7;

  // Longest run before it is written out, literal flush threshold, store cap
  localparam logic [LEN_W-1:0] RUN_LIMIT = 7'd125;
  localparam logic [LEN_W-1:0] LIT_LIMIT = 7'd125;
  localparam logic [LEN_W-1:0] LIT_MAX   = 7'd127;

  localparam logic [CKSUM_W-1:0] CHECK_BIAS = 32'h0001_D4C1;

  // Work still to do for the current input byte, in order of execution
  typedef struct packed {
    logic run1;
    logic flush1;
    logic push_h;
    logic push_b;
    logic flush2;
    logic run2;
  } phase_flags_t;

endpackage

`default_nettype wire

// ----- sv/rlerac_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlerac_in_if
// Raw byte channel into the coder: one chunk byte per word.
// ----------------------------------------------------------------------------
interface rlerac_in_if
  import rlerac_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

// ----- sv/rlerac_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlerac_out_if
// Encoded result channel: up to eight coded bytes per word plus chunk status.
// ----------------------------------------------------------------------------
interface rlerac_out_if
  import rlerac_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  packed_bytes;
  logic [COUNT_W-1:0] byte_count;
  logic               chunk_done;
  logic [CKSUM_W-1:0] chunk_checksum;
  logic               last_of_burst;

  modport source (output valid, output packed_bytes, output byte_count,
                  output chunk_done, output chunk_checksum, output last_of_burst,
                  input ready);
  modport sink   (input valid, input packed_bytes, input byte_count,
                  input chunk_done, input chunk_checksum, input last_of_burst,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/rle_encoder_rotate_add_checksum.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rle_encoder_rotate_add_checksum
// PackBits-style run-length coder with a rotate-add checksum over coded bytes.
// ----------------------------------------------------------------------------
// Sequence: a byte is taken in the idle state, then the sequencer does each
//   literal store write (0 to 2) and emits each coded byte (0 to 130) in turn.
// A new input byte is taken only once the sequencer is back in idle, and the
//   emitter sends one byte per cycle unless the output word is held.
// Reset: control state, run/literal state and checksum clear at once; the
//   literal store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module rle_encoder_rotate_add_checksum
  import rlerac_pkg::*;
#(
  parameter int unsigned LITERAL_DEPTH    = 128,
  parameter int unsigned BYTES_PER_RESULT = 8
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  rlerac_in_if.sink     in_i,
  rlerac_out_if.source  out_o
);

  localparam int unsigned AW    = $clog2(LITERAL_DEPTH);
  localparam int unsigned CW    = $clog2(BYTES_PER_RESULT + 1);
  localparam int unsigned ACC_W = DATA_W * BYTES_PER_RESULT;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_RUN_HDR  = 3'd1;
  localparam logic [2:0] S_RUN_VAL  = 3'd2;
  localparam logic [2:0] S_LIT_HDR  = 3'd3;
  localparam logic [2:0] S_LIT_DATA = 3'd4;
  localparam logic [2:0] S_PUSH_H   = 3'd5;
  localparam logic [2:0] S_PUSH_B   = 3'd6;

  function automatic logic [2:0] pick_state(phase_flags_t f);
    logic [2:0] s;
    s = S_IDLE;
    priority if (f.run1)   s = S_RUN_HDR;
    else if     (f.flush1) s = S_LIT_HDR;
    else if     (f.push_h) s = S_PUSH_H;
    else if     (f.push_b) s = S_PUSH_B;
    else if     (f.flush2) s = S_LIT_HDR;
    else if     (f.run2)   s = S_RUN_HDR;
    else                   s = S_IDLE;
    return s;
  endfunction

  function automatic phase_flags_t drop_top(phase_flags_t f);
    phase_flags_t r;
    r = f;
    priority if (f.run1)   r.run1   = 1'b0;
    else if     (f.flush1) r.flush1 = 1'b0;
    else if     (f.push_h) r.push_h = 1'b0;
    else if     (f.push_b) r.push_b = 1'b0;
    else if     (f.flush2) r.flush2 = 1'b0;
    else if     (f.run2)   r.run2   = 1'b0;
    else                   r        = f;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] run_header(logic [LEN_W-1:0] n);
    logic [8:0] t;
    t = 9'd257 - {2'b00, n};
    return t[7:0];
  endfunction

  function automatic logic [CKSUM_W-1:0] cksum_step(logic [CKSUM_W-1:0] c,
                                                    logic [DATA_W-1:0] d);
    logic [CKSUM_W-1:0] t;
    t = {c[31:8], c[7:0] + d};
    return {t[28:0], t[31:29]};
  endfunction

  // Literal store
  logic [DATA_W-1:0] store_mem [LITERAL_DEPTH];
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [DATA_W-1:0] wr_data, rd_data_q;

  // Sequencer and coder state
  logic [2:0]         state_q, state_d;
  phase_flags_t       flags_q, flags_d, nf;
  logic               fin_q, fin_d;
  logic [DATA_W-1:0]  run_hdr_q, run_hdr_d, run_val_q, run_val_d;
  logic [DATA_W-1:0]  push_h_q, push_h_d, push_b_q, push_b_d;
  logic [LEN_W-1:0]   lit_len_q, lit_len_d, idx_q, idx_d;
  logic [DATA_W-1:0]  held_q, held_d;
  logic               hv_q, hv_d, ra_q, ra_d;
  logic [LEN_W-1:0]   rl_q, rl_d, rl_inc, idx_inc;
  logic [CKSUM_W-1:0] ck_q, ck_d, ck_next;

  // Packer and output register
  logic [ACC_W-1:0]   acc_q, acc_d, acc_new;
  logic [CW-1:0]      cnt_q, cnt_d, cnt_inc;
  logic               ov_q, ov_d;
  logic [WORD_W-1:0]  ob_q, ob_d;
  logic [COUNT_W-1:0] oc_q, oc_d;
  logic               od_q, od_d, ol_q, ol_d;
  logic [CKSUM_W-1:0] ock_q, ock_d;

  // Emission
  logic              emit_valid, phase_end, emit_last, completes, emit_ok, fire;
  logic [DATA_W-1:0] emit_byte;
  logic              accept;
  logic [DATA_W-1:0] b;
  logic              fin;

  assign accept  = in_i.valid && in_i.ready;
  assign b       = in_i.data_byte;
  assign fin     = in_i.final_byte;
  assign rl_inc  = rl_q + 7'd1;
  assign idx_inc = idx_q + 7'd1;

  always_comb begin
    emit_valid = 1'b0;
    phase_end  = 1'b0;
    emit_byte  = '0;
    unique case (state_q)
      S_RUN_HDR: begin
        emit_valid = 1'b1;
        emit_byte  = run_hdr_q;
      end
      S_RUN_VAL: begin
        emit_valid = 1'b1;
        emit_byte  = run_val_q;
        phase_end  = 1'b1;
      end
      S_LIT_HDR: begin
        emit_valid = 1'b1;
        emit_byte  = {1'b0, lit_len_q - 7'd1};
      end
      S_LIT_DATA: begin
        emit_valid = 1'b1;
        emit_byte  = rd_data_q;
        phase_end  = (idx_inc == lit_len_q);
      end
      default: begin
        emit_valid = 1'b0;
      end
    endcase
    emit_last = phase_end
                && !(flags_q.run1 || flags_q.flush1 || flags_q.flush2 || flags_q.run2);
    cnt_inc   = cnt_q + CW'(1);
    completes = (cnt_inc == CW'(BYTES_PER_RESULT)) || emit_last;
    // stall only the byte that closes a word while the output word is held
    emit_ok   = !completes || !ov_q || out_o.ready;
    fire      = emit_valid && emit_ok;
    acc_new   = acc_q | (ACC_W'(emit_byte) << {cnt_q, 3'b000});
    ck_next   = cksum_step(ck_q, emit_byte);
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    flags_d   = flags_q;
    fin_d     = fin_q;
    run_hdr_d = run_hdr_q;
    run_val_d = run_val_q;
    push_h_d  = push_h_q;
    push_b_d  = push_b_q;
    lit_len_d = lit_len_q;
    idx_d     = idx_q;
    held_d    = held_q;
    hv_d      = hv_q;
    ra_d      = ra_q;
    rl_d      = rl_q;
    wr_en     = 1'b0;
    wr_addr   = AW'(lit_len_q);
    wr_data   = push_b_q;
    rd_en     = 1'b0;
    rd_addr   = '0;
    nf        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          fin_d    = fin;
          push_h_d = held_q;
          push_b_d = b;
          if (ra_q) begin
            if (b == held_q && rl_q < RUN_LIMIT) begin
              if (rl_inc >= RUN_LIMIT || fin) begin
                nf.run1   = 1'b1;
                run_hdr_d = run_header(rl_inc);
                run_val_d = held_q;
                ra_d      = 1'b0;
                rl_d      = '0;
                hv_d      = 1'b0;
              end else begin
                rl_d = rl_inc;
              end
            end else begin
              nf.run1   = 1'b1;
              run_hdr_d = run_header(rl_q);
              run_val_d = held_q;
              ra_d      = 1'b0;
              rl_d      = '0;
              held_d    = b;
              hv_d      = 1'b1;
              if (fin) begin
                nf.push_b = 1'b1;
                nf.flush2 = 1'b1;
                hv_d      = 1'b0;
              end
            end
          end else if (hv_q) begin
            nf.flush1 = (lit_len_q != '0 && held_q == b) || (lit_len_q > LIT_LIMIT);
            if (held_q == b) begin
              hv_d = 1'b0;
              if (fin) begin
                nf.run2   = 1'b1;
                run_hdr_d = run_header(7'd2);
                run_val_d = held_q;
              end else begin
                ra_d = 1'b1;
                rl_d = 7'd2;
              end
            end else begin
              nf.push_h = 1'b1;
              held_d    = b;
              if (fin) begin
                nf.push_b = 1'b1;
                nf.flush2 = 1'b1;
                hv_d      = 1'b0;
              end
            end
          end else begin
            held_d = b;
            hv_d   = 1'b1;
            if (fin) begin
              nf.push_b = 1'b1;
              nf.flush2 = 1'b1;
              hv_d      = 1'b0;
            end
          end
          if (fin) begin
            held_d = '0;
            hv_d   = 1'b0;
            ra_d   = 1'b0;
            rl_d   = '0;
          end
          state_d = pick_state(nf);
          flags_d = drop_top(nf);
        end
      end
      S_RUN_HDR: begin
        if (fire) state_d = S_RUN_VAL;
      end
      S_RUN_VAL: begin
        if (fire) begin
          state_d = pick_state(flags_q);
          flags_d = drop_top(flags_q);
        end
      end
      S_LIT_HDR: begin
        // fetch the first stored byte along with the header
        if (fire) begin
          rd_en   = 1'b1;
          rd_addr = '0;
          idx_d   = '0;
          state_d = S_LIT_DATA;
        end
      end
      S_LIT_DATA: begin
        if (fire) begin
          if (phase_end) begin
            lit_len_d = '0;
            state_d   = pick_state(flags_q);
            flags_d   = drop_top(flags_q);
          end else begin
            rd_en   = 1'b1;
            rd_addr = AW'(idx_inc);
            idx_d   = idx_inc;
          end
        end
      end
      S_PUSH_H, S_PUSH_B: begin
        wr_data = (state_q == S_PUSH_H) ? push_h_q : push_b_q;
        if (lit_len_q < LIT_MAX) begin
          wr_en     = 1'b1;
          lit_len_d = lit_len_q + 7'd1;
        end
        state_d = pick_state(flags_q);
        flags_d = drop_top(flags_q);
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Packer, checksum and output register
  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    ck_d  = ck_q;
    ov_d  = ov_q;
    ob_d  = ob_q;
    oc_d  = oc_q;
    od_d  = od_q;
    ol_d  = ol_q;
    ock_d = ock_q;
    if (ov_q && out_o.ready) ov_d = 1'b0;
    if (fire) begin
      ck_d = (emit_last && fin_q) ? '0 : ck_next;
      if (completes) begin
        ov_d  = 1'b1;
        ob_d  = WORD_W'(acc_new);
        oc_d  = COUNT_W'(cnt_inc);
        od_d  = emit_last && fin_q;
        ol_d  = emit_last;
        ock_d = (emit_last && fin_q) ? (ck_next - CHECK_BIAS) : '0;
        acc_d = '0;
        cnt_d = '0;
      end else begin
        acc_d = acc_new;
        cnt_d = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      flags_q   <= '0;
      fin_q     <= 1'b0;
      lit_len_q <= '0;
      idx_q     <= '0;
      held_q    <= '0;
      hv_q      <= 1'b0;
      ra_q      <= 1'b0;
      rl_q      <= '0;
      ck_q      <= '0;
      acc_q     <= '0;
      cnt_q     <= '0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      flags_q   <= flags_d;
      fin_q     <= fin_d;
      lit_len_q <= lit_len_d;
      idx_q     <= idx_d;
      held_q    <= held_d;
      hv_q      <= hv_d;
      ra_q      <= ra_d;
      rl_q      <= rl_d;
      ck_q      <= ck_d;
      acc_q     <= acc_d;
      cnt_q     <= cnt_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_hdr_q <= run_hdr_d;
    run_val_q <= run_val_d;
    push_h_q  <= push_h_d;
    push_b_q  <= push_b_d;
    ob_q      <= ob_d;
    oc_q      <= oc_d;
    od_q      <= od_d;
    ol_q      <= ol_d;
    ock_q     <= ock_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) store_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_data_q <= store_mem[rd_addr];
  end

  assign in_i.ready           = (state_q == S_IDLE);
  assign out_o.valid          = ov_q;
  assign out_o.packed_bytes   = ob_q;
  assign out_o.byte_count     = oc_q;
  assign out_o.chunk_done     = od_q;
  assign out_o.chunk_checksum = ock_q;
  assign out_o.last_of_burst  = ol_q;

`ifndef SYNTH
  a_run_no_literal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ra_q && state_q == S_IDLE) |-> (lit_len_q == '0 && !hv_q))
    else $error("literal run pending while a run is open");

  a_run_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ra_q |-> (rl_q >= 7'd2 && rl_q < RUN_LIMIT))
    else $error("open run length out of range");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.chunk_done) |-> out_o.last_of_burst)
    else $error("chunk end not on the last word of its byte");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.byte_count != '0
                     && out_o.byte_count <= COUNT_W'(BYTES_PER_RESULT)))
    else $error("word byte count out of range");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Sends chunks of raw bytes into the run-length coder and checks each coded
// word, field by field, against a behavioral coder that advances on every
// accepted byte. Covers chunk edges, run and literal limits, random chunks
// and a long output stall.
// ----------------------------------------------------------------------------
module tb_top
  import rlerac_pkg::*;
;

  localparam int unsigned BYTES_PER_WORD = 8;
  localparam int unsigned STORE_DEPTH    = 128;
  localparam int unsigned DRAIN_CYCLES   = 200;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned MAX_REPORTS    = 100;
  localparam int unsigned RANDOM_BYTES   = 30;

  typedef struct packed {
    logic [WORD_W-1:0]  packed_bytes;
    logic [COUNT_W-1:0] byte_count;
    logic               chunk_done;
    logic [CKSUM_W-1:0] chunk_checksum;
    logic               last_of_burst;
  } coded_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rlerac_in_if  in_if ();
  rlerac_out_if out_if ();

  rle_encoder_rotate_add_checksum dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Behavioral coder state
  logic [DATA_W-1:0]  lit_mem [STORE_DEPTH];
  int unsigned        lit_len;
  logic [DATA_W-1:0]  held;
  bit                 held_v;
  bit                 in_run;
  int unsigned        run_len;
  logic [CKSUM_W-1:0] cksum;
  logic [DATA_W-1:0]  step_bytes[$];
  coded_word_t        pending_words[$];

  int err_count  = 0;
  int word_count = 0;
  bit src_idle   = 1'b1;
  bit snk_idle   = 1'b1;
  bit sink_hold  = 1'b0;
  int sink_gap   = 0;

  function automatic void clear_coder();
    lit_len = 0;
    held    = '0;
    held_v  = 1'b0;
    in_run  = 1'b0;
    run_len = 0;
    cksum   = '0;
  endfunction

  // Add into the low byte, then rotate left by 3
  function automatic void emit_byte(input logic [DATA_W-1:0] d);
    logic [CKSUM_W-1:0] c;
    c = {cksum[31:8], cksum[7:0] + d};
    cksum = {c[28:0], c[31:29]};
    step_bytes.push_back(d);
  endfunction

  function automatic void push_lit(input logic [DATA_W-1:0] b);
    if (lit_len < LIT_MAX) begin
      lit_mem[lit_len] = b;
      lit_len++;
    end
  endfunction

  function automatic void flush_lit();
    if (lit_len == 0) return;
    emit_byte(8'(lit_len - 1));
    for (int i = 0; i < lit_len; i++) emit_byte(lit_mem[i]);
    lit_len = 0;
  endfunction

  function automatic void put_run(input int unsigned n, input logic [DATA_W-1:0] v);
    emit_byte(8'(257 - n));
    emit_byte(v);
  endfunction

  function automatic void encode_byte(input logic [DATA_W-1:0] b, input bit fin);
    logic [CKSUM_W-1:0] sum;
    int unsigned        n;
    int unsigned        cnt;
    coded_word_t        w;
    sum = '0;
    step_bytes.delete();
    if (in_run) begin
      if (b == held && run_len < RUN_LIMIT) begin
        run_len++;
        if (run_len >= RUN_LIMIT || fin) begin
          put_run(run_len, held);
          in_run  = 1'b0;
          run_len = 0;
          held_v  = 1'b0;
        end
      end else begin
        put_run(run_len, held);
        in_run  = 1'b0;
        run_len = 0;
        held    = b;
        held_v  = 1'b1;
        if (fin) begin
          push_lit(b);
          flush_lit();
          held_v = 1'b0;
        end
      end
    end else if (held_v) begin
      if ((lit_len != 0 && held == b) || lit_len > LIT_LIMIT) flush_lit();
      if (held == b) begin
        held_v = 1'b0;
        if (fin) begin
          put_run(2, held);
        end else begin
          in_run  = 1'b1;
          run_len = 2;
        end
      end else begin
        push_lit(held);
        held = b;
        if (fin) begin
          push_lit(b);
          flush_lit();
          held_v = 1'b0;
        end
      end
    end else begin
      held   = b;
      held_v = 1'b1;
      if (fin) begin
        push_lit(b);
        flush_lit();
        held_v = 1'b0;
      end
    end
    if (fin) begin
      sum = cksum - CHECK_BIAS;
      clear_coder();
    end
    // Pack the coded bytes eight to a word
    n = 0;
    while (n < step_bytes.size()) begin
      cnt = step_bytes.size() - n;
      if (cnt > BYTES_PER_WORD) cnt = BYTES_PER_WORD;
      w = '0;
      for (int i = 0; i < cnt; i++) w.packed_bytes[8*i +: 8] = step_bytes[n + i];
      w.byte_count     = cnt[COUNT_W-1:0];
      n += cnt;
      w.last_of_burst  = (n == step_bytes.size());
      w.chunk_done     = w.last_of_burst && fin;
      w.chunk_checksum = w.chunk_done ? sum : '0;
      pending_words.push_back(w);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("word %0d: %s got %h expected %h", word_count, what, got, want);
  endtask

  always @(posedge clk_i) begin : check_words
    coded_word_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      word_count++;
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", out_if.packed_bytes, '0);
      end else begin
        want = pending_words.pop_front();
        if (out_if.packed_bytes !== want.packed_bytes)
          report_mismatch("packed_bytes", out_if.packed_bytes, want.packed_bytes);
        if (out_if.byte_count !== want.byte_count)
          report_mismatch("byte_count", 64'(out_if.byte_count), 64'(want.byte_count));
        if (out_if.chunk_done !== want.chunk_done)
          report_mismatch("chunk_done", 64'(out_if.chunk_done), 64'(want.chunk_done));
        if (out_if.chunk_checksum !== want.chunk_checksum)
          report_mismatch("chunk_checksum", 64'(out_if.chunk_checksum),
                          64'(want.chunk_checksum));
        if (out_if.last_of_burst !== want.last_of_burst)
          report_mismatch("last_of_burst", 64'(out_if.last_of_burst),
                          64'(want.last_of_burst));
      end
      sink_gap = snk_idle ? $urandom_range(0, 3) : 0;
    end
  end

  // Receiver: wait the drawn gap after each word, hold while sink_hold is set
  initial begin : drive_ready
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni || sink_hold) begin
        out_if.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        out_if.ready <= 1'b0;
        sink_gap--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [DATA_W-1:0] d, input bit fin);
    int gap;
    gap = src_idle ? $urandom_range(0, 3) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= d;
    in_if.final_byte <= fin;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    encode_byte(d, fin);
  endtask

  task automatic send_chunk(input logic [DATA_W-1:0] chunk[$]);
    foreach (chunk[i]) send_byte(chunk[i], i == chunk.size() - 1);
  endtask

  task automatic test_chunk_edges();
    logic [DATA_W-1:0] chunk[$];
    chunk = '{8'h00};                                 send_chunk(chunk);
    chunk = '{8'hFF};                                 send_chunk(chunk);
    // run of two closed by the final byte
    chunk = '{8'h7E, 8'h7E};                          send_chunk(chunk);
    chunk = '{8'h01, 8'h02, 8'h03};                   send_chunk(chunk);
    // run broken by a different final byte
    chunk = '{8'hAA, 8'hAA, 8'hAA, 8'h80};            send_chunk(chunk);
    // literal flushed by a run that the final byte closes
    chunk = '{8'h10, 8'h20, 8'h20, 8'h20, 8'h20};     send_chunk(chunk);
    chunk = '{8'h33, 8'h44, 8'h44, 8'h55};            send_chunk(chunk);
    chunk = '{8'hFF, 8'h00, 8'hFF, 8'h00};            send_chunk(chunk);
  endtask

  task automatic test_run_limit();
    logic [DATA_W-1:0] chunk[$];
    // limit reached, then a fresh chain of equal bytes and a literal tail
    chunk.delete();
    repeat (128) chunk.push_back(8'h5A);
    chunk.push_back(8'h11);
    send_chunk(chunk);
  endtask

  task automatic test_literal_limit();
    logic [DATA_W-1:0] chunk[$];
    // adjacent bytes always differ, so everything stays literal
    chunk.delete();
    for (int i = 0; i < 128; i++) chunk.push_back(8'(i * 37 + 5));
    send_chunk(chunk);
  endtask

  task automatic test_random_chunks();
    logic [DATA_W-1:0] chunk[$];
    logic [DATA_W-1:0] v;
    int                sent;
    int                segs;
    int                len;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      chunk.delete();
      src_idle = ($urandom_range(0, 3) != 0);
      snk_idle = ($urandom_range(0, 3) != 0);
      segs = $urandom_range(1, 5);
      repeat (segs) begin
        v = 8'($urandom);
        case ($urandom_range(0, 2))
          0: begin
            len = $urandom_range(1, 8);
            repeat (len) chunk.push_back(v);
          end
          1: begin
            len = $urandom_range(1, 12);
            repeat (len) chunk.push_back(8'($urandom));
          end
          default: begin
            // two-value alphabet: short runs mixed with literals
            len = $urandom_range(1, 16);
            repeat (len) chunk.push_back(v ^ 8'($urandom_range(0, 1)));
          end
        endcase
      end
      send_chunk(chunk);
      sent += chunk.size();
    end
    src_idle = 1'b1;
    snk_idle = 1'b1;
  endtask

  task automatic test_backpressure();
    logic [DATA_W-1:0] chunk[$];
    chunk.delete();
    for (int i = 0; i < 16; i++) chunk.push_back(8'(i * 11 + 3));
    repeat (8) chunk.push_back(8'h99);
    repeat (6) chunk.push_back(8'($urandom));
    src_idle = 1'b0;
    fork
      begin
        sink_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        sink_hold = 1'b0;
      end
      send_chunk(chunk);
    join
    src_idle = 1'b1;
  endtask

  initial begin : run_tests
    in_if.valid      = 1'b0;
    in_if.data_byte  = '0;
    in_if.final_byte = 1'b0;
    clear_coder();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_chunk_edges();
    test_run_limit();
    test_literal_limit();
    test_random_chunks();
    test_backpressure();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(64'd10_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
